// File: hdl/ansi_escape_filter_assert.svh
// ----------------------------------------------------------------------------
// ansi_escape_filter assertion macros
// Concurrent assertion wrappers clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef ANSI_ESCAPE_FILTER_ASSERT_SVH
`define ANSI_ESCAPE_FILTER_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define AEF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aef assertion failed");
// next-cycle implication
`define AEF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aef assertion failed");
`else
`define AEF_ASSERT_NOW(lbl, ante, cons)
`define AEF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: hdl/aef_pkg.sv
// ----------------------------------------------------------------------------
// aef_pkg
// Shared constants, command/status types and byte classifiers.
// ----------------------------------------------------------------------------
package aef_pkg;

  localparam int KEPT_W = 16;

  localparam logic [7:0] ESC_BYTE  = 8'h1B;
  localparam logic [7:0] CSI_OPEN  = 8'h5B;  // '['
  localparam logic [7:0] COLOR_CMD = 8'h6D;  // 'm'

  localparam logic [1:0] KEEP_STRIP = 2'd0;
  localparam logic [1:0] KEEP_COLOR = 2'd1;
  localparam logic [1:0] KEEP_CMDS  = 2'd2;

  typedef enum logic [2:0] {
    EMIT_IN,
    EMIT_ESC,
    EMIT_OPEN,
    EMIT_PARAM,
    EMIT_CMD,
    EMIT_DONE
  } emit_sel_t;

  typedef struct packed {
    logic      buf_clear;
    logic      buf_push;
    logic      ovf_set;
    logic      cmd_save;
    logic      rd_step;
    logic      emit;
    logic      emit_last;
    emit_sel_t emit_sel;
  } cmd_t;

  typedef struct packed {
    logic byte_zero;
    logic byte_esc;
    logic byte_open;
    logic byte_param;
    logic cmd_keep;
    logic seq_full;
    logic seq_empty;
    logic rd_last;
    logic out_free;
  } sts_t;

  // digits, ';' and '='
  function automatic logic is_param(input logic [7:0] c);
    logic r;
    r = ((c >= 8'h30) && (c <= 8'h39)) || (c == 8'h3B) || (c == 8'h3D);
    return r;
  endfunction

  // A B C D H I J K f h l m s u
  function automatic logic is_command(input logic [7:0] c);
    logic r;
    case (c)
      8'h41, 8'h42, 8'h43, 8'h44, 8'h48, 8'h49, 8'h4A, 8'h4B,
      8'h66, 8'h68, 8'h6C, 8'h6D, 8'h73, 8'h75: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/aef_ctrl.sv
// ----------------------------------------------------------------------------
// aef_ctrl
// Escape parser state machine and replay sequencer.
// ----------------------------------------------------------------------------
`include "ansi_escape_filter_assert.svh"

module aef_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  aef_pkg::sts_t sts,
  output aef_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_TEXT,
    ST_ESC,
    ST_CSI,
    ST_REP_OPEN,
    ST_REP_PARAM,
    ST_REP_CMD
  } state_t;

  state_t state;
  state_t state_next;
  logic   accepting;
  logic   take;

  always_comb begin
    cmd          = '0;
    cmd.emit_sel = aef_pkg::EMIT_IN;
    state_next   = state;
    accepting    = (state == ST_TEXT) || (state == ST_ESC) || (state == ST_CSI);
    in_stall     = !(accepting && sts.out_free);
    take         = in_valid && !in_stall;

    if (take && sts.byte_zero) begin
      // end of string from any phase
      cmd.emit      = 1'b1;
      cmd.emit_last = 1'b1;
      cmd.emit_sel  = aef_pkg::EMIT_DONE;
      cmd.buf_clear = 1'b1;
      state_next    = ST_TEXT;
    end else begin
      case (state)
        ST_TEXT: begin
          if (take) begin
            if (sts.byte_esc) begin
              state_next = ST_ESC;
            end else begin
              cmd.emit      = 1'b1;
              cmd.emit_last = 1'b1;
              cmd.emit_sel  = aef_pkg::EMIT_IN;
            end
          end
        end
        ST_ESC: begin
          if (take) begin
            if (sts.byte_open) begin
              cmd.buf_clear = 1'b1;
              state_next    = ST_CSI;
            end else begin
              state_next = ST_TEXT;
            end
          end
        end
        ST_CSI: begin
          if (take) begin
            if (sts.byte_param) begin
              if (sts.seq_full) begin
                cmd.ovf_set = 1'b1;
              end else begin
                cmd.buf_push = 1'b1;
              end
            end else if (sts.cmd_keep) begin
              cmd.cmd_save = 1'b1;
              cmd.emit     = 1'b1;
              cmd.emit_sel = aef_pkg::EMIT_ESC;
              state_next   = ST_REP_OPEN;
            end else begin
              state_next = ST_TEXT;
            end
          end
        end
        ST_REP_OPEN: begin
          if (sts.out_free) begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = aef_pkg::EMIT_OPEN;
            state_next   = sts.seq_empty ? ST_REP_CMD : ST_REP_PARAM;
          end
        end
        ST_REP_PARAM: begin
          if (sts.out_free) begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = aef_pkg::EMIT_PARAM;
            cmd.rd_step  = 1'b1;
            if (sts.rd_last) begin
              state_next = ST_REP_CMD;
            end
          end
        end
        ST_REP_CMD: begin
          if (sts.out_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_last = 1'b1;
            cmd.emit_sel  = aef_pkg::EMIT_CMD;
            state_next    = ST_TEXT;
          end
        end
        default: begin
          state_next = ST_TEXT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_TEXT;
    end else begin
      state <= state_next;
    end
  end

  `AEF_ASSERT_NOW(a_emit_room, cmd.emit, sts.out_free)
  `AEF_ASSERT_NOW(a_param_nonempty, state == ST_REP_PARAM, !sts.seq_empty)
  `AEF_ASSERT_NOW(a_push_room, cmd.buf_push, !sts.seq_full)
  `AEF_ASSERT_NEXT(a_keep_opens, cmd.cmd_save, state == ST_REP_OPEN)

endmodule

// File: hdl/aef_dp.sv
// ----------------------------------------------------------------------------
// aef_dp
// Sequence buffer, kept counter, mode register and output register.
// ----------------------------------------------------------------------------
`include "ansi_escape_filter_assert.svh"

module aef_dp #(
  parameter int MAX_SEQUENCE = 16,
  parameter int COUNT_WIDTH  = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  keep_mode,
  input  logic [7:0]                  in_byte,
  input  aef_pkg::cmd_t               cmd,
  output aef_pkg::sts_t               sts,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_byte,
  output logic                        run_last,
  output logic                        string_done,
  output logic [aef_pkg::KEPT_W-1:0]  kept_count
);

  localparam int LEN_W       = $clog2(MAX_SEQUENCE);
  localparam int PARAM_LIMIT = MAX_SEQUENCE - 3;

  logic [1:0]             mode;
  logic [7:0]             seq_mem [MAX_SEQUENCE];
  logic [LEN_W-1:0]       seq_len;
  logic                   seq_ovf;
  logic [7:0]             cmd_byte;
  logic [LEN_W-1:0]       rd_ptr;
  logic [LEN_W-1:0]       rd_ptr_inc;
  logic [LEN_W-1:0]       rd_ptr_next;
  logic [7:0]             rd_data;
  logic [COUNT_WIDTH-1:0] cnt;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [COUNT_WIDTH-1:0] cnt_show;
  logic [31:0]            cnt_wide;
  logic [7:0]             emit_byte;
  logic                   emit_done;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= aef_pkg::KEEP_STRIP;
    end else if (cfg_valid) begin
      mode <= keep_mode;
    end
  end

  // status
  assign rd_ptr_inc = rd_ptr + LEN_W'(1);

  always_comb begin
    sts.byte_zero  = (in_byte == 8'h00);
    sts.byte_esc   = (in_byte == aef_pkg::ESC_BYTE);
    sts.byte_open  = (in_byte == aef_pkg::CSI_OPEN);
    sts.byte_param = aef_pkg::is_param(in_byte);
    sts.cmd_keep   = !seq_ovf &&
                     (((mode == aef_pkg::KEEP_CMDS) && aef_pkg::is_command(in_byte)) ||
                      ((mode == aef_pkg::KEEP_COLOR) && (in_byte == aef_pkg::COLOR_CMD)));
    sts.seq_full   = (seq_len >= LEN_W'(PARAM_LIMIT));
    sts.seq_empty  = (seq_len == '0);
    sts.rd_last    = (rd_ptr_inc == seq_len);
    sts.out_free   = !out_valid || !out_stall;
  end

  // sequence buffer: read address runs one step ahead so rd_data tracks rd_ptr
  assign rd_ptr_next = cmd.cmd_save ? '0 : (cmd.rd_step ? rd_ptr_inc : rd_ptr);

  always_ff @(posedge clk) begin
    if (cmd.buf_push) begin
      seq_mem[seq_len] <= in_byte;
    end
    rd_data <= seq_mem[rd_ptr_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_len <= '0;
      seq_ovf <= 1'b0;
      rd_ptr  <= '0;
    end else begin
      rd_ptr <= rd_ptr_next;
      if (cmd.buf_clear) begin
        seq_len <= '0;
        seq_ovf <= 1'b0;
      end else if (cmd.buf_push) begin
        seq_len <= seq_len + LEN_W'(1);
      end else if (cmd.ovf_set) begin
        seq_ovf <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cmd_save) begin
      cmd_byte <= in_byte;
    end
  end

  // result value select
  always_comb begin
    case (cmd.emit_sel)
      aef_pkg::EMIT_IN:    emit_byte = in_byte;
      aef_pkg::EMIT_ESC:   emit_byte = aef_pkg::ESC_BYTE;
      aef_pkg::EMIT_OPEN:  emit_byte = aef_pkg::CSI_OPEN;
      aef_pkg::EMIT_PARAM: emit_byte = rd_data;
      aef_pkg::EMIT_CMD:   emit_byte = cmd_byte;
      default:             emit_byte = 8'h00;
    endcase
  end

  assign emit_done = (cmd.emit_sel == aef_pkg::EMIT_DONE);
  assign cnt_inc   = (cnt == '1) ? cnt : cnt + COUNT_WIDTH'(1);
  assign cnt_show  = emit_done ? cnt : cnt_inc;
  assign cnt_wide  = 32'(cnt_show);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      cnt       <= emit_done ? '0 : cnt_inc;
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte    <= emit_byte;
      run_last    <= cmd.emit_last;
      string_done <= emit_done;
      kept_count  <= cnt_wide[aef_pkg::KEPT_W-1:0];
    end
  end

  `AEF_ASSERT_NOW(a_done_is_last, out_valid && string_done, run_last)
  `AEF_ASSERT_NEXT(a_clear_empties, cmd.buf_clear, seq_len == '0 && !seq_ovf)

endmodule

// File: hdl/ansi_escape_filter.sv
// ----------------------------------------------------------------------------
// ansi_escape_filter
// Strips ANSI escape sequences from zero-terminated byte strings.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_byte carries one byte per request;
//   a zero byte ends the string. Output channel out_valid/out_stall carries
//   out_byte, run_last, string_done and kept_count. keep_mode is written
//   through cfg_valid/cfg_ready (always ready) while the block is idle:
//   0 strip all, 1 keep color ('m') sequences, 2 keep known commands.
// Timing:
//   A result appears in the output register the cycle after its byte is
//   accepted, so plain text streams at one byte per cycle while out_stall is
//   low. A kept CSI sequence of N parameters replays N+3 results, one per
//   cycle while out_stall is low, and in_stall is held after its command
//   byte while the replay sequencer walks the parameter buffer.
// Stall:
//   The single output register is refilled in the cycle it is taken, so
//   in_stall follows out_stall while a result waits; nothing is lost.
// Reset:
//   rst (synchronous) returns the parser to text, clears the count and
//   out_valid and sets keep_mode to strip-all.
// ----------------------------------------------------------------------------
module ansi_escape_filter #(
  parameter int MAX_SEQUENCE = 16,
  parameter int COUNT_WIDTH  = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  keep_mode,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_byte,
  output logic                        run_last,
  output logic                        string_done,
  output logic [aef_pkg::KEPT_W-1:0]  kept_count
);

  aef_pkg::cmd_t cmd;
  aef_pkg::sts_t sts;

  // parser and replay sequencer
  aef_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // buffer, counter, mode register, output register
  aef_dp #(
    .MAX_SEQUENCE (MAX_SEQUENCE),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .keep_mode   (keep_mode),
    .in_byte     (in_byte),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .run_last    (run_last),
    .string_done (string_done),
    .kept_count  (kept_count)
  );

endmodule

// File: dv/ansi_escape_filter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansi_escape_filter_test
// Self-checking bench for the ANSI escape stripper. A short table of directed
// requests comes first, then randomized strings built mostly from well-formed
// CSI sequences. Every accepted input request runs through a behavioral
// predictor, and every accepted output request is checked field by field
// against the oldest predicted result.
// ----------------------------------------------------------------------------
module ansi_escape_filter_test;

  localparam int MAX_SEQ    = 16;
  localparam int COUNT_W    = 16;
  localparam int PARAM_MAX  = MAX_SEQ - 3;         // parameters that fit a replay
  localparam int unsigned COUNT_MAX = (1 << COUNT_W) - 1;
  localparam int RAND_ITEMS = 260;                 // on top of the directed rows
  localparam int SETTLE     = MAX_SEQ + 4;         // longest replay plus pipeline
  localparam int HOLD_CYCLES = 200;                // one long receiver hold-off
  localparam int LIMIT      = 3_000_000;

  // mode 3 is not decoded by the block and must act like strip-all
  localparam logic [1:0] KEEP_ALT_STRIP = 2'd3;

  localparam logic [7:0] CMD_SET [14] = '{
    8'h41, 8'h42, 8'h43, 8'h44, 8'h48, 8'h49, 8'h4A,
    8'h4B, 8'h66, 8'h68, 8'h6C, 8'h6D, 8'h73, 8'h75
  };

  typedef struct packed {
    logic [7:0]                 data;
    logic                       last;
    logic                       done;
    logic [aef_pkg::KEPT_W-1:0] count;
  } out_item_t;

  typedef enum logic {ROW_BYTE, ROW_MODE} row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] val;      // byte to send, or keep_mode for a mode row
    logic       typed;    // expected result written out below
    out_item_t  want;
  } dir_row_t;

  typedef enum logic [1:0] {PH_TEXT, PH_ESC, PH_CSI} parse_ph_t;

  // Directed requests. Typed rows give one result that is obvious by eye;
  // everything else falls back on the predictor.
  localparam dir_row_t DIR_ROWS [28] = '{
    // strip-all mode straight out of reset
    '{ROW_BYTE, 8'h48,              1'b1, '{8'h48, 1'b1, 1'b0, 16'd1}},  // 'H'
    '{ROW_BYTE, 8'hFF,              1'b1, '{8'hFF, 1'b1, 1'b0, 16'd2}},  // top byte
    '{ROW_BYTE, aef_pkg::ESC_BYTE,  1'b0, '0},
    '{ROW_BYTE, 8'h78,              1'b0, '0},                  // ESC 'x' dropped
    '{ROW_BYTE, aef_pkg::ESC_BYTE,  1'b0, '0},
    '{ROW_BYTE, aef_pkg::CSI_OPEN,  1'b0, '0},
    '{ROW_BYTE, aef_pkg::COLOR_CMD, 1'b0, '0},                  // CSI m stripped
    '{ROW_BYTE, 8'h00,              1'b1, '{8'h00, 1'b1, 1'b1, 16'd2}},  // end
    // color only
    '{ROW_MODE, 8'(aef_pkg::KEEP_COLOR), 1'b0, '0},
    '{ROW_BYTE, aef_pkg::ESC_BYTE,  1'b0, '0},
    '{ROW_BYTE, aef_pkg::CSI_OPEN,  1'b0, '0},
    '{ROW_BYTE, 8'h33,              1'b0, '0},                  // '3'
    '{ROW_BYTE, 8'h3B,              1'b0, '0},                  // ';'
    '{ROW_BYTE, aef_pkg::COLOR_CMD, 1'b0, '0},                  // replay of 5
    '{ROW_BYTE, aef_pkg::ESC_BYTE,  1'b0, '0},
    '{ROW_BYTE, aef_pkg::ESC_BYTE,  1'b0, '0},                  // ESC ESC
    '{ROW_BYTE, 8'h61,              1'b0, '0},                  // 'a' passes
    '{ROW_BYTE, aef_pkg::ESC_BYTE,  1'b0, '0},
    '{ROW_BYTE, aef_pkg::CSI_OPEN,  1'b0, '0},
    '{ROW_BYTE, 8'h80,              1'b0, '0},                  // high byte as command
    // known commands
    '{ROW_MODE, 8'(aef_pkg::KEEP_CMDS), 1'b0, '0},
    '{ROW_BYTE, aef_pkg::ESC_BYTE,  1'b0, '0},
    '{ROW_BYTE, aef_pkg::CSI_OPEN,  1'b0, '0},
    '{ROW_BYTE, 8'h3D,              1'b0, '0},                  // '='
    '{ROW_BYTE, 8'h48,              1'b0, '0},                  // 'H' replayed
    '{ROW_BYTE, aef_pkg::ESC_BYTE,  1'b0, '0},
    '{ROW_BYTE, aef_pkg::CSI_OPEN,  1'b0, '0},
    '{ROW_BYTE, 8'h00,              1'b0, '0}                   // zero inside CSI
  };

  logic                       clk;
  logic                       rst;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [1:0]                 keep_mode;
  logic                       in_valid;
  logic                       in_stall;
  logic [7:0]                 in_byte;
  logic                       out_valid;
  logic                       out_stall;
  logic [7:0]                 out_byte;
  logic                       run_last;
  logic                       string_done;
  logic [aef_pkg::KEPT_W-1:0] kept_count;

  // predictor state
  parse_ph_t   parse_ph = PH_TEXT;
  logic [7:0]  seq_buf [MAX_SEQ];
  int          seq_len = 0;
  bit          seq_ovf = 1'b0;
  int unsigned kept_tot = 0;
  logic [1:0]  cur_mode = aef_pkg::KEEP_STRIP;

  out_item_t step_q [$];     // results of the byte just accepted
  out_item_t owed_out [$];   // results not yet seen on the output

  int fails = 0;
  int sent = 0;
  int hold_asks = 0;
  bit burst = 1'b0;          // sender offers back to back

  ansi_escape_filter #(
    .MAX_SEQUENCE(MAX_SEQ),
    .COUNT_WIDTH (COUNT_W)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .keep_mode  (keep_mode),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .string_done(string_done),
    .kept_count (kept_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic bit param_char(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || c == 8'h3B || c == 8'h3D;
  endfunction

  function automatic bit known_cmd(input logic [7:0] c);
    bit hit;
    hit = 1'b0;
    foreach (CMD_SET[i]) if (CMD_SET[i] == c) hit = 1'b1;
    return hit;
  endfunction

  // one kept byte: the count goes up first, saturating
  function automatic void keep_out(input logic [7:0] b, input logic last);
    out_item_t r;
    if (kept_tot < COUNT_MAX) kept_tot++;
    r.data  = b;
    r.last  = last;
    r.done  = 1'b0;
    r.count = kept_tot[aef_pkg::KEPT_W-1:0];
    step_q.push_back(r);
  endfunction

  function automatic void filter_step(input logic [7:0] c);
    out_item_t r;
    bit keep;
    int i;
    step_q.delete();
    if (c == 8'h00) begin
      // the zero byte closes the string from any phase
      r.data  = 8'h00;
      r.last  = 1'b1;
      r.done  = 1'b1;
      r.count = kept_tot[aef_pkg::KEPT_W-1:0];
      step_q.push_back(r);
      parse_ph = PH_TEXT;
      seq_len  = 0;
      seq_ovf  = 1'b0;
      kept_tot = 0;
    end else begin
      case (parse_ph)
        PH_ESC: begin
          if (c == aef_pkg::CSI_OPEN) begin
            parse_ph = PH_CSI;
            seq_len  = 0;
            seq_ovf  = 1'b0;
          end else begin
            parse_ph = PH_TEXT;
          end
        end
        PH_CSI: begin
          if (param_char(c)) begin
            if (seq_len < PARAM_MAX) begin
              seq_buf[seq_len] = c;
              seq_len++;
            end else begin
              seq_ovf = 1'b1;
            end
          end else begin
            // mode is taken at the command byte
            keep = !seq_ovf &&
                   ((cur_mode == aef_pkg::KEEP_CMDS && known_cmd(c)) ||
                    (cur_mode == aef_pkg::KEEP_COLOR && c == aef_pkg::COLOR_CMD));
            parse_ph = PH_TEXT;
            if (keep) begin
              keep_out(aef_pkg::ESC_BYTE, 1'b0);
              keep_out(aef_pkg::CSI_OPEN, 1'b0);
              for (i = 0; i < seq_len; i++) keep_out(seq_buf[i], 1'b0);
              keep_out(c, 1'b1);
            end
          end
        end
        default: begin
          if (c == aef_pkg::ESC_BYTE) parse_ph = PH_ESC;
          else keep_out(c, 1'b1);
        end
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Pacing: most gaps short, a few long
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Receiver side. A hold-off request from the stimulus freezes the output
  // for HOLD_CYCLES so the block backs up and stalls its input.
  initial begin : rx_pace
    int pace_left;
    int hold_seen;
    pace_left = 0;
    hold_seen = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_asks) begin
        hold_seen++;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        out_stall = 1'b0;
        pace_left = 0;
      end else if (pace_left != 0) begin
        pace_left--;
      end else if (out_stall) begin
        out_stall = 1'b0;
        pace_left = $urandom_range(0, 20);
      end else begin
        pace_left = pick_gap();
        out_stall = (pace_left != 0);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output checking
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string field, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      fails++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (owed_out.size() == 0) begin
        fails++;
        $display("%0t: unexpected result, expected none, got byte %0h done %0b",
                 $time, out_byte, string_done);
      end else begin
        want = owed_out.pop_front();
        check_field("out_byte", 16'(want.data), 16'(out_byte));
        check_field("run_last", 16'(want.last), 16'(run_last));
        check_field("string_done", 16'(want.done), 16'(string_done));
        check_field("kept_count", want.count, kept_count);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request drivers; all called at a falling edge
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b, input logic typed = 1'b0,
                           input out_item_t want = '0);
    int gap;
    gap = burst ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_byte  = b;
    do @(posedge clk); while (in_stall);
    filter_step(b);
    if (typed) owed_out.push_back(want);
    else foreach (step_q[i]) owed_out.push_back(step_q[i]);
    sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // sender pause until the block has handed back everything, then let any
  // replay that produces nothing further run out
  task automatic wait_drained();
    in_valid = 1'b0;
    while (owed_out.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_mode(input logic [1:0] m);
    cfg_valid = 1'b1;
    keep_mode = m;
    do @(posedge clk); while (!cfg_ready);
    cur_mode = m;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] c;
    if ($urandom_range(0, 4) != 0) c = 8'($urandom_range(8'h20, 8'h7E));
    else c = 8'($urandom_range(1, 255));
    if (c == aef_pkg::ESC_BYTE) c = 8'h7F;
    return c;
  endfunction

  task automatic send_text(input int n);
    repeat (n) push_byte(text_byte());
  endtask

  // ESC '[' params command; lengths straddle the replay limit now and then
  task automatic send_csi();
    int n;
    int r;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 70) n = $urandom_range(0, 4);
    else if (r < 90) n = $urandom_range(5, 12);
    else n = $urandom_range(PARAM_MAX, MAX_SEQ);
    push_byte(aef_pkg::ESC_BYTE);
    push_byte(aef_pkg::CSI_OPEN);
    repeat (n) begin
      r = $urandom_range(0, 11);
      if (r < 10) push_byte(8'(8'h30 + r));
      else if (r == 10) push_byte(8'h3B);
      else push_byte(8'h3D);
    end
    r = $urandom_range(0, 99);
    if (r < 5) c = 8'h00;                                  // string cut short
    else if (r < 50) c = CMD_SET[$urandom_range(0, 13)];
    else if (r < 75) c = aef_pkg::COLOR_CMD;
    else if (r < 88) c = 8'($urandom_range(1, 255));
    else c = 8'($urandom_range(128, 255));
    push_byte(c);
  endtask

  task automatic send_string();
    int r;
    burst = ($urandom_range(0, 4) == 0);
    repeat ($urandom_range(1, 8)) begin
      r = $urandom_range(0, 99);
      if (r < 35) send_text($urandom_range(1, 6));
      else if (r < 85) send_csi();
      else begin
        push_byte(aef_pkg::ESC_BYTE);
        push_byte(8'($urandom_range(1, 255)));
      end
    end
    if ($urandom_range(0, 9) == 0) wait_drained();
    push_byte(8'h00);
    burst = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int ph_idx;
    logic [1:0] mode_plan [4];
    mode_plan = '{KEEP_ALT_STRIP, aef_pkg::KEEP_COLOR, aef_pkg::KEEP_CMDS,
                  aef_pkg::KEEP_STRIP};
    rst       = 1'b1;
    cfg_valid = 1'b0;
    keep_mode = aef_pkg::KEEP_STRIP;
    in_valid  = 1'b0;
    in_byte   = 8'h00;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].kind == ROW_MODE) begin
        wait_drained();
        write_mode(DIR_ROWS[i].val[1:0]);
      end else begin
        push_byte(DIR_ROWS[i].val, DIR_ROWS[i].typed, DIR_ROWS[i].want);
      end
    end

    // random phases, each under one mode; every mode value shows up early
    ph_idx = 0;
    sent = 0;
    while (sent < RAND_ITEMS) begin
      wait_drained();
      write_mode(ph_idx < 4 ? mode_plan[ph_idx] : 2'($urandom_range(0, 3)));
      if (ph_idx == 0) begin
        // long output hold while the sender keeps offering text
        hold_asks++;
        burst = 1'b1;
        send_text(48);
        burst = 1'b0;
      end
      repeat ($urandom_range(1, 3)) send_string();
      ph_idx++;
    end

    wait_drained();
    if (fails == 0) begin
      $display("PASS ansi_escape_filter");
    end else begin
      $display("FAIL ansi_escape_filter");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL ansi_escape_filter");
    $finish;
  end

endmodule
